// ----- hdl/csv_structure_validator_unit_assert.svh -----
// Assertion macros for the validator core.
`ifndef CSV_STRUCTURE_VALIDATOR_UNIT_ASSERT_SVH
`define CSV_STRUCTURE_VALIDATOR_UNIT_ASSERT_SVH

// Check on every clock edge outside reset.
`define CSVV_CHECK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define CSVV_CHECK_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/csvv_pkg.sv -----
package csvv_pkg;

	localparam logic [7:0] QUOTE_BYTE   = 8'h22;
	localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
	localparam logic [7:0] SEP_RESET    = 8'h3B;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_EOF  = 1'b1;

	localparam logic [2:0] STATUS_OK        = 3'd0;
	localparam logic [2:0] STATUS_EOF_QUOTE = 3'd1;
	localparam logic [2:0] STATUS_BAD_QUOTE = 3'd2;
	localparam logic [2:0] STATUS_QUOTE_UNQ = 3'd3;
	localparam logic [2:0] STATUS_COLUMNS   = 3'd4;

	typedef struct packed {
		logic       kind;
		logic [7:0] data_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [23:0] row_total;
		logic [15:0] column_total;
		logic [15:0] error_column;
		logic [23:0] error_row;
	} result_t;

	// Stage 1 to core: one item in flight plus the separator in use.
	typedef struct packed {
		logic       go;
		item_t      item;
		logic [7:0] sep;
	} scan_req_t;

endpackage

// ----- hdl/csvv_core.sv -----
`include "csv_structure_validator_unit_assert.svh"

module csvv_core #(
	parameter int COLUMN_BITS = 16,
	parameter int ROW_BITS    = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  csvv_pkg::scan_req_t req,
	output logic               advance,
	output logic               result_valid,
	input  logic               result_stall,
	output csvv_pkg::result_t  result
);
	import csvv_pkg::*;

	typedef enum logic [1:0] {
		PH_START,
		PH_UNQUOTED,
		PH_QUOTED,
		PH_QSEEN
	} phase_t;

	localparam int CW = COLUMN_BITS + 1;

	phase_t                 phase_q, phase_d;
	logic                   first_q, first_d;
	logic                   err_q, err_d;
	logic [COLUMN_BITS-1:0] ccount_q, ccount_d;
	logic [COLUMN_BITS-1:0] cpos_q, cpos_d;
	logic [ROW_BITS-1:0]    rcount_q, rcount_d;
	logic                   result_valid_q;
	result_t                result_s2;

	logic                   fire;
	result_t                res;
	logic [COLUMN_BITS-1:0] ccount_inc, cpos_inc;
	logic [ROW_BITS-1:0]    rcount_inc, rcount_inc2;
	logic                   cols_match;
	logic                   is_nl, is_sep, is_q;
	logic [15:0]            err_col;
	logic [23:0]            err_row;

	assign advance      = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result       = result_s2;

	assign ccount_inc  = (ccount_q == '1) ? ccount_q : ccount_q + COLUMN_BITS'(1);
	assign cpos_inc    = (cpos_q == '1) ? cpos_q : cpos_q + COLUMN_BITS'(1);
	assign rcount_inc  = (rcount_q == '1) ? rcount_q : rcount_q + ROW_BITS'(1);
	assign rcount_inc2 = (rcount_inc == '1) ? rcount_inc : rcount_inc + ROW_BITS'(1);
	// Compare one bit wider so a saturated position never matches.
	assign cols_match  = ({1'b0, cpos_q} + CW'(1)) == {1'b0, ccount_q};

	assign is_nl  = req.item.data_byte == NEWLINE_BYTE;
	assign is_sep = req.item.data_byte == req.sep;
	assign is_q   = req.item.data_byte == QUOTE_BYTE;

	assign err_col = first_q ? 16'(ccount_q - COLUMN_BITS'(1)) : 16'(cpos_inc);
	assign err_row = first_q ? 24'd0 : 24'(rcount_inc);

	always_comb begin
		phase_d  = phase_q;
		first_d  = first_q;
		err_d    = err_q;
		ccount_d = ccount_q;
		cpos_d   = cpos_q;
		rcount_d = rcount_q;
		fire     = 1'b0;
		res      = '0;
		if (req.go && req.item.kind == KIND_EOF) begin
			if (!err_q) begin
				fire = 1'b1;
				if (phase_q == PH_QUOTED) begin
					res.status       = STATUS_EOF_QUOTE;
					res.error_column = err_col;
					res.error_row    = err_row;
				end else if (first_q) begin
					res.status       = STATUS_OK;
					res.row_total    = 24'd1;
					res.column_total = 16'(ccount_q);
				end else if (cols_match) begin
					res.status       = STATUS_OK;
					res.row_total    = 24'(rcount_inc);
					res.column_total = 16'(ccount_q);
				end else begin
					res.status    = STATUS_COLUMNS;
					res.error_row = 24'(rcount_inc);
				end
			end
			// Rearm for the next table.
			err_d    = 1'b0;
			phase_d  = PH_START;
			first_d  = 1'b1;
			ccount_d = COLUMN_BITS'(1);
			cpos_d   = '0;
			rcount_d = ROW_BITS'(1);
		end else if (req.go && !err_q) begin
			if (phase_q == PH_QUOTED) begin
				if (is_q) begin
					phase_d = PH_QSEEN;
				end
			end else if (is_nl) begin
				phase_d = PH_START;
				if (first_q) begin
					first_d = 1'b0;
				end else begin
					rcount_d = rcount_inc;
					if (!cols_match) begin
						err_d         = 1'b1;
						fire          = 1'b1;
						res.status    = STATUS_COLUMNS;
						res.error_row = 24'(rcount_inc2);
					end else begin
						cpos_d = '0;
					end
				end
			end else if (is_sep) begin
				phase_d = PH_START;
				if (first_q) begin
					ccount_d = ccount_inc;
				end else begin
					cpos_d = cpos_inc;
				end
			end else begin
				case (phase_q)
					PH_START: begin
						phase_d = is_q ? PH_QUOTED : PH_UNQUOTED;
					end
					PH_UNQUOTED: begin
						if (is_q) begin
							err_d            = 1'b1;
							fire             = 1'b1;
							res.status       = STATUS_QUOTE_UNQ;
							res.error_column = err_col;
							res.error_row    = err_row;
						end
					end
					PH_QSEEN: begin
						if (is_q) begin
							phase_d = PH_QUOTED;
						end else begin
							err_d            = 1'b1;
							fire             = 1'b1;
							res.status       = STATUS_BAD_QUOTE;
							res.error_column = err_col;
							res.error_row    = err_row;
						end
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_START;
			first_q        <= 1'b1;
			err_q          <= 1'b0;
			ccount_q       <= COLUMN_BITS'(1);
			cpos_q         <= '0;
			rcount_q       <= ROW_BITS'(1);
			result_valid_q <= 1'b0;
			result_s2      <= '0;
		end else begin
			phase_q  <= phase_d;
			first_q  <= first_d;
			err_q    <= err_d;
			ccount_q <= ccount_d;
			cpos_q   <= cpos_d;
			rcount_q <= rcount_d;
			if (req.go) begin
				result_valid_q <= fire;
				result_s2      <= res;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	`CSVV_CHECK(a_err_latches, (req.go && fire && req.item.kind == KIND_DATA) |=> err_q, "error without latch")
	`CSVV_CHECK(a_err_silent, (req.go && err_q && req.item.kind == KIND_DATA) |=> !result_valid_q, "byte after error produced a result")
	`CSVV_CHECK(a_eof_rearm, (req.go && req.item.kind == KIND_EOF) |=> (phase_q == PH_START && first_q && !err_q), "end of file did not rearm")
	`CSVV_CHECK(a_width_fixed, (!first_q && !(req.go && req.item.kind == KIND_EOF)) |=> $stable(ccount_q), "column count moved after first row")
	`CSVV_CHECK_ALWAYS(a_ccount_nonzero, (!arst_n || ccount_q != '0), "column count is zero")

endmodule

// ----- hdl/csv_structure_validator_unit.sv -----
// Streaming structure check of a delimited text table, one byte item per clock. Send data bytes
// with kind 0 and close each table with a kind 1 end-of-file item; the block answers with at most
// one verdict per table: success with row and column totals, or the first error (end of file in a
// quoted cell, bad byte after a closing quote, quote in an unquoted cell, each with its column
// and row; wrong column count, with its row). Bytes after an error are dropped until end of
// file, which then gives no verdict and rearms the block. Each item passes the input register,
// then the state update into the result register; the block sustains one item per cycle and
// holds input only while a finished verdict waits at a stalled output with another behind it.
// The separator register (reset ';') is written through the cfg channel while the block is idle.
module csv_structure_validator_unit #(
	parameter int COLUMN_BITS = 16,
	parameter int ROW_BITS    = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  csvv_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output csvv_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [7:0]        cfg_data
);
	import csvv_pkg::*;

	logic      valid_s1;
	item_t     item_s1;
	logic [7:0] sep_q;
	logic      advance;
	logic      accept;
	scan_req_t req;

	// Stall only when the stage 1 item cannot move into the core.
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;
	// Take separator writes only with no item in flight.
	assign cfg_ready  = !valid_s1;

	assign req.go   = valid_s1 && advance;
	assign req.item = item_s1;
	assign req.sep  = sep_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			sep_q    <= SEP_RESET;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				sep_q <= cfg_data;
			end
		end
	end

	// Hold the payload with the valid bit; no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	csvv_core #(
		.COLUMN_BITS(COLUMN_BITS),
		.ROW_BITS   (ROW_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.advance     (advance),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

// ----- bench/csv_structure_validator_unit_tb.sv -----
module csv_structure_validator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import csvv_pkg::*;

	localparam logic [15:0] COL_MAX = 16'hFFFF;
	localparam logic [23:0] ROW_MAX = 24'hFFFFFF;
	localparam int N_PHASES        = 8;
	localparam int ITEMS_PER_PHASE = 165;
	localparam int HOLD_CYCLES     = 80;   // long receiver hold-off during the pressure burst
	localparam int BURST_ITEMS     = 24;
	localparam int SETTLE_CYCLES   = 8;    // input and result registers plus margin
	localparam int DRAIN_LIMIT     = 4000;

	// Cell scanner phase and byte classification, mirrored from the block's behavior.
	typedef enum logic [1:0] {CELL_START, CELL_PLAIN, CELL_QUOTED, CELL_CLOSED} cell_ph_t;
	typedef enum logic [2:0] {
		SCAN_NONE, SCAN_ROW, SCAN_CELL, SCAN_BAD_CLOSE, SCAN_STRAY_QUOTE
	} scan_ev_t;

	// One directed step: the item, and where the verdict is obvious, that verdict typed in.
	typedef struct packed {
		item_t   it;
		bit      typed;
		bit      fires;
		result_t v;
	} script_row_t;

	localparam int SCRIPT_LEN = 27;
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		// empty table right after reset: one row, one column
		'{'{KIND_EOF, 8'hFF}, 1'b1, 1'b1, '{STATUS_OK, 24'd1, 16'd1, 16'd0, 24'd0}},
		// two rows of two cells
		'{'{KIND_DATA, "a"}, 1'b0, 1'b0, '0},
		'{'{KIND_DATA, SEP_RESET}, 1'b0, 1'b0, '0},
		'{'{KIND_DATA, NEWLINE_BYTE}, 1'b0, 1'b0, '0},
		'{'{KIND_DATA, "c"}, 1'b0, 1'b0, '0},
		'{'{KIND_DATA, SEP_RESET}, 1'b0, 1'b0, '0},
		'{'{KIND_DATA, "d"}, 1'b0, 1'b0, '0},
		'{'{KIND_EOF, 8'h00}, 1'b1, 1'b1, '{STATUS_OK, 24'd2, 16'd2, 16'd0, 24'd0}},
		// quote inside an unquoted cell, then the rearming end of file
		'{'{KIND_DATA, "x"}, 1'b0, 1'b0, '0},
		'{'{KIND_DATA, QUOTE_BYTE}, 1'b1, 1'b1, '{STATUS_QUOTE_UNQ, 24'd0, 16'd0, 16'd0, 24'd0}},
		'{'{KIND_EOF, 8'h00}, 1'b1, 1'b0, '0},
		// quoted cell with an escaped quote, then a stray byte after the close
		'{'{KIND_DATA, QUOTE_BYTE}, 1'b0, 1'b0, '0},
		'{'{KIND_DATA, "a"}, 1'b0, 1'b0, '0},
		'{'{KIND_DATA, QUOTE_BYTE}, 1'b0, 1'b0, '0},
		'{'{KIND_DATA, QUOTE_BYTE}, 1'b0, 1'b0, '0},
		'{'{KIND_DATA, QUOTE_BYTE}, 1'b0, 1'b0, '0},
		'{'{KIND_DATA, 8'h00}, 1'b1, 1'b1, '{STATUS_BAD_QUOTE, 24'd0, 16'd0, 16'd0, 24'd0}},
		'{'{KIND_EOF, 8'hFF}, 1'b1, 1'b0, '0},
		// end of file inside an open quoted cell
		'{'{KIND_DATA, QUOTE_BYTE}, 1'b0, 1'b0, '0},
		'{'{KIND_DATA, 8'hFF}, 1'b0, 1'b0, '0},
		'{'{KIND_EOF, 8'h00}, 1'b1, 1'b1, '{STATUS_EOF_QUOTE, 24'd0, 16'd0, 16'd0, 24'd0}},
		// second row short by one cell: error at its newline
		'{'{KIND_DATA, SEP_RESET}, 1'b0, 1'b0, '0},
		'{'{KIND_DATA, NEWLINE_BYTE}, 1'b0, 1'b0, '0},
		'{'{KIND_DATA, NEWLINE_BYTE}, 1'b1, 1'b1, '{STATUS_COLUMNS, 24'd0, 16'd0, 16'd0, 24'd3}},
		'{'{KIND_EOF, 8'h00}, 1'b1, 1'b0, '0},
		// trailing newline counts as a second row
		'{'{KIND_DATA, NEWLINE_BYTE}, 1'b0, 1'b0, '0},
		'{'{KIND_EOF, 8'hFF}, 1'b1, 1'b1, '{STATUS_OK, 24'd2, 16'd1, 16'd0, 24'd0}}
	};

	logic       clk;
	logic       arst_n       = 1'b0;
	logic       item_valid   = 1'b0;
	logic       item_stall;
	item_t      item         = '0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	result_t    result;
	logic       cfg_valid    = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data     = '0;

	// Predictor state: the separator in force and the scan position in the current table.
	logic [7:0]  sep_char;
	cell_ph_t    cell_ph;
	logic        first_row;
	logic [15:0] col_count;
	logic [15:0] col_pos;
	logic [23:0] row_count;
	logic        err_held;

	result_t verdict_q [$];     // verdicts still owed by the block, oldest first
	item_t   table_items [$];   // one generated table, end of file item included
	int      mismatches = 0;
	int      items_sent = 0;
	bit      idle_on    = 1'b1;
	bit      burst_on   = 1'b0;
	bit      hold_req   = 1'b0;

	csv_structure_validator_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: far above the slowest legal run.
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	task automatic flag_mismatch(input string what, input logic [23:0] got,
			input logic [23:0] want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic logic [15:0] col_inc(input logic [15:0] n);
		return (n == COL_MAX) ? n : n + 16'd1;
	endfunction

	function automatic logic [23:0] row_inc(input logic [23:0] n);
		return (n == ROW_MAX) ? n : n + 24'd1;
	endfunction

	// Compare wide so a saturated position never wraps onto the column count.
	function automatic bit row_complete();
		return ({1'b0, col_pos} + 17'd1) == {1'b0, col_count};
	endfunction

	function automatic void restart_table();
		cell_ph   = CELL_START;
		first_row = 1'b1;
		col_count = 16'd1;
		col_pos   = 16'd0;
		row_count = 24'd1;
	endfunction

	// Positions follow the file: first row reports count minus one and row 0.
	function automatic result_t error_verdict(input logic [2:0] code);
		result_t v;
		v = '0;
		v.status = code;
		if (first_row) begin
			v.error_column = col_count - 16'd1;
		end else begin
			v.error_column = col_inc(col_pos);
			v.error_row    = row_inc(row_count);
		end
		return v;
	endfunction

	// Advance the predictor by one accepted item; return 1 when it yields a verdict.
	function automatic bit predict_verdict(input item_t it, output result_t v);
		scan_ev_t   ev;
		logic [7:0] c;
		bit         fires;
		v     = '0;
		ev    = SCAN_NONE;
		c     = it.data_byte;
		fires = 1'b0;
		if (it.kind == KIND_EOF) begin
			if (!err_held) begin
				fires = 1'b1;
				if (cell_ph == CELL_QUOTED) begin
					v = error_verdict(STATUS_EOF_QUOTE);
				end else if (first_row) begin
					v.status       = STATUS_OK;
					v.row_total    = 24'd1;
					v.column_total = col_count;
				end else if (row_complete()) begin
					v.status       = STATUS_OK;
					v.row_total    = row_inc(row_count);
					v.column_total = col_count;
				end else begin
					v.status    = STATUS_COLUMNS;
					v.error_row = row_inc(row_count);
				end
			end
			err_held = 1'b0;
			restart_table();
			return fires;
		end
		if (err_held)
			return 1'b0;
		// Outside a quoted cell, newline wins over the separator, the separator over the quote.
		case (cell_ph)
			CELL_START: begin
				if (c == NEWLINE_BYTE) ev = SCAN_ROW;
				else if (c == sep_char) ev = SCAN_CELL;
				else cell_ph = (c == QUOTE_BYTE) ? CELL_QUOTED : CELL_PLAIN;
			end
			CELL_PLAIN: begin
				if (c == NEWLINE_BYTE) ev = SCAN_ROW;
				else if (c == sep_char) ev = SCAN_CELL;
				else if (c == QUOTE_BYTE) ev = SCAN_STRAY_QUOTE;
			end
			CELL_QUOTED: begin
				if (c == QUOTE_BYTE) cell_ph = CELL_CLOSED;
			end
			default: begin
				if (c == NEWLINE_BYTE) ev = SCAN_ROW;
				else if (c == sep_char) ev = SCAN_CELL;
				else if (c == QUOTE_BYTE) cell_ph = CELL_QUOTED;  // doubled quote
				else ev = SCAN_BAD_CLOSE;
			end
		endcase
		case (ev)
			SCAN_ROW: begin
				cell_ph = CELL_START;
				if (first_row) begin
					first_row = 1'b0;
				end else begin
					row_count = row_inc(row_count);
					if (!row_complete()) begin
						err_held    = 1'b1;
						fires       = 1'b1;
						v.status    = STATUS_COLUMNS;
						v.error_row = row_inc(row_count);
					end else begin
						col_pos = 16'd0;
					end
				end
			end
			SCAN_CELL: begin
				cell_ph = CELL_START;
				if (first_row) col_count = col_inc(col_count);
				else col_pos = col_inc(col_pos);
			end
			SCAN_BAD_CLOSE: begin
				err_held = 1'b1;
				fires    = 1'b1;
				v        = error_verdict(STATUS_BAD_QUOTE);
			end
			SCAN_STRAY_QUOTE: begin
				err_held = 1'b1;
				fires    = 1'b1;
				v        = error_verdict(STATUS_QUOTE_UNQ);
			end
			default: ;
		endcase
		return fires;
	endfunction

	// Table text byte that is none of newline, quote or separator.
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255));
		while (b == NEWLINE_BYTE || b == QUOTE_BYTE || b == sep_char);
		return b;
	endfunction

	// Any byte, skewed toward the ones that steer the scanner.
	function automatic logic [7:0] noisy_byte();
		case ($urandom_range(0, 3))
			0: return NEWLINE_BYTE;
			1: return QUOTE_BYTE;
			2: return sep_char;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void push_data(input logic [7:0] b);
		table_items.push_back(item_t'{KIND_DATA, b});
	endfunction

	// Build one table: mostly well formed with random cells, some broken, some pure noise.
	task automatic compose_table();
		int ncols;
		int nrows;
		int ncells;
		int len;
		int k;
		table_items.delete();
		if ($urandom_range(0, 9) == 0) begin
			len = $urandom_range(1, 15);
			repeat (len) push_data(noisy_byte());
		end else begin
			ncols = $urandom_range(1, 4);
			nrows = $urandom_range(1, 5);
			for (int r = 0; r < nrows; r++) begin
				ncells = ncols;
				// now and then a row with one cell too many or too few
				if ($urandom_range(0, 11) == 0)
					ncells = ($urandom_range(0, 1) || ncols == 1) ? ncols + 1 : ncols - 1;
				for (int c = 0; c < ncells; c++) begin
					if (c > 0)
						push_data(sep_char);
					case ($urandom_range(0, 3))
						0: ;  // empty cell
						1: begin
							len = $urandom_range(1, 4);
							repeat (len) push_data(plain_byte());
						end
						default: begin
							push_data(QUOTE_BYTE);
							len = $urandom_range(0, 4);
							repeat (len) begin
								case ($urandom_range(0, 7))
									0, 1: begin
										push_data(QUOTE_BYTE);
										push_data(QUOTE_BYTE);
									end
									2: push_data(NEWLINE_BYTE);
									3: push_data(sep_char);
									default: push_data(plain_byte());
								endcase
							end
							push_data(QUOTE_BYTE);
						end
					endcase
				end
				if (r < nrows - 1 || $urandom_range(0, 1))
					push_data(NEWLINE_BYTE);
			end
			// break a few tables: drop one stray byte in, or cut the tail off
			if ($urandom_range(0, 9) == 0 && table_items.size() > 0) begin
				k = $urandom_range(0, table_items.size() - 1);
				if ($urandom_range(0, 1)) begin
					table_items.insert(k, item_t'{KIND_DATA, noisy_byte()});
				end else begin
					while (table_items.size() > k)
						void'(table_items.pop_back());
				end
			end
		end
		table_items.push_back(item_t'{KIND_EOF, 8'($urandom_range(0, 255))});
	endtask

	// Present one item after a random gap and hold it until the block takes it.
	task automatic offer_item(input item_t it);
		int gap;
		int r;
		gap = 0;
		if (idle_on && !burst_on) begin
			r = $urandom_range(0, 99);
			if (r >= 90) gap = $urandom_range(10, 30);
			else if (r >= 55) gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic feed_item(input item_t it);
		result_t v;
		offer_item(it);
		if (predict_verdict(it, v))
			verdict_q.push_back(v);
	endtask

	// Drop valid, let every owed verdict arrive, then let the pipeline go quiet.
	task automatic settle_idle();
		int waited;
		waited = 0;
		item_valid <= 1'b0;
		while (verdict_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (verdict_q.size() != 0) begin
			flag_mismatch("verdicts never delivered", 24'(verdict_q.size()), 24'd0);
			verdict_q.delete();
		end
	endtask

	task automatic write_separator(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sep_char = value;
	endtask

	// Check every verdict the block hands over against the oldest one owed.
	initial begin
		result_t v;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall) begin
				if (verdict_q.size() == 0) begin
					flag_mismatch("verdict with none owed, status", 24'(result.status), 24'd0);
				end else begin
					v = verdict_q.pop_front();
					if (result.status !== v.status)
						flag_mismatch("status", 24'(result.status), 24'(v.status));
					if (result.row_total !== v.row_total)
						flag_mismatch("row_total", result.row_total, v.row_total);
					if (result.column_total !== v.column_total)
						flag_mismatch("column_total", 24'(result.column_total),
							24'(v.column_total));
					if (result.error_column !== v.error_column)
						flag_mismatch("error_column", 24'(result.error_column),
							24'(v.error_column));
					if (result.error_row !== v.error_row)
						flag_mismatch("error_row", result.error_row, v.error_row);
				end
			end
		end
	end

	// Receiver: runs of acceptance and stalls of random length; on request, one long hold-off.
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (!idle_on) begin
				result_stall <= 1'b0;
			end else begin
				n = $urandom_range(0, 99);
				if (n < 60) begin
					result_stall <= 1'b0;
					n = $urandom_range(1, 6);
				end else if (n < 92) begin
					result_stall <= 1'b1;
					n = $urandom_range(1, 3);
				end else begin
					result_stall <= 1'b1;
					n = $urandom_range(10, 30);
				end
				repeat (n - 1) @(posedge clk);
			end
		end
	end

	initial begin
		logic [7:0] sep_plan [N_PHASES];
		result_t    v;
		bit         fires;
		int         quota;

		sep_plan = '{8'h2C, 8'h00, 8'hFF, NEWLINE_BYTE, QUOTE_BYTE, 8'h09, 8'h00, SEP_RESET};
		sep_plan[6] = 8'($urandom_range(0, 255));

		sep_char = SEP_RESET;
		err_held = 1'b0;
		restart_table();

		// Hold reset, then release it on an edge.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed walk at the reset separator; obvious verdicts are typed in the table.
		foreach (SCRIPT[i]) begin
			offer_item(SCRIPT[i].it);
			fires = predict_verdict(SCRIPT[i].it, v);
			if (SCRIPT[i].typed) begin
				if (SCRIPT[i].fires)
					verdict_q.push_back(SCRIPT[i].v);
			end else if (fires) begin
				verdict_q.push_back(v);
			end
		end

		// Random tables, one separator per phase; every third phase runs without idling.
		for (int p = 0; p < N_PHASES; p++) begin
			settle_idle();
			write_separator(sep_plan[p]);
			idle_on = (p % 3 != 2);
			if (p == 1) begin
				// Stall the output for a long stretch while end-of-file items keep coming,
				// so verdicts pile up and the block backs up its input.
				hold_req = 1'b1;
				burst_on = 1'b1;
				repeat (BURST_ITEMS)
					feed_item(item_t'{KIND_EOF, 8'($urandom_range(0, 255))});
				burst_on = 1'b0;
			end
			quota = items_sent + ITEMS_PER_PHASE;
			while (items_sent < quota) begin
				compose_table();
				foreach (table_items[i])
					feed_item(table_items[i]);
			end
		end

		settle_idle();
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
